### rtl/pcc_pkg.sv
`timescale 1ns / 1ps

package pcc_pkg;

	localparam int DW     = 36;
	localparam int ZW     = 26;
	localparam int MAG_W  = 33;
	localparam int AIDX_W = 5;

	localparam logic [15:0] GAIN_Q16 = 16'd39797;

	localparam logic signed [16:0] ANG_FULL_IN = 17'sd46080;
	localparam logic signed [16:0] ANG_HALF_IN = 17'sd23040;
	localparam logic signed [16:0] ANG_QTR_IN  = 17'sd11520;

	localparam logic signed [ZW-1:0] DEG180    = 26'sd5898240;
	localparam logic signed [ZW-1:0] ANG_CLAMP = 26'sd23040;

	typedef struct packed {
		logic                 mode;
		logic                 flip;
		logic                 origin;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
	} beat_t;

	function automatic logic signed [ZW-1:0] atan_lut(input logic [AIDX_W-1:0] idx);
		logic signed [ZW-1:0] v;
		unique case (idx)
			5'd0:    v = 26'sd1474560;
			5'd1:    v = 26'sd870484;
			5'd2:    v = 26'sd459940;
			5'd3:    v = 26'sd233473;
			5'd4:    v = 26'sd117189;
			5'd5:    v = 26'sd58652;
			5'd6:    v = 26'sd29333;
			5'd7:    v = 26'sd14667;
			5'd8:    v = 26'sd7334;
			5'd9:    v = 26'sd3667;
			5'd10:   v = 26'sd1833;
			5'd11:   v = 26'sd917;
			5'd12:   v = 26'sd458;
			5'd13:   v = 26'sd229;
			5'd14:   v = 26'sd115;
			5'd15:   v = 26'sd57;
			5'd16:   v = 26'sd29;
			5'd17:   v = 26'sd14;
			5'd18:   v = 26'sd7;
			5'd19:   v = 26'sd4;
			5'd20:   v = 26'sd2;
			5'd21:   v = 26'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

### rtl/pcc_prep.sv
`timescale 1ns / 1ps

module pcc_prep import pcc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               command,
	input  logic signed [15:0] x_in,
	input  logic signed [15:0] y_in,
	input  logic        [15:0] radius_in,
	input  logic signed [15:0] angle_in,
	output logic               vld_s1,
	output beat_t              beat_s1
);

	beat_t beat_d;

	always_comb begin
		logic signed [16:0] fold_a;
		logic signed [16:0] turn_a;
		logic               rflip;
		logic        [31:0] rprod;
		logic signed [DW-1:0] rx;
		logic signed [ZW-1:0] rz;
		logic signed [DW-1:0] xs;
		logic signed [DW-1:0] ys;
		logic signed [DW-1:0] vx;
		logic signed [DW-1:0] vy;
		logic signed [ZW-1:0] base;
		logic                 xneg;

		fold_a = 17'(angle_in);
		if (fold_a > ANG_HALF_IN) begin
			fold_a = fold_a - ANG_FULL_IN;
		end else if (fold_a < -ANG_HALF_IN) begin
			fold_a = fold_a + ANG_FULL_IN;
		end

		rflip  = 1'b0;
		turn_a = fold_a;
		if (fold_a > ANG_QTR_IN) begin
			turn_a = fold_a - ANG_HALF_IN;
			rflip  = 1'b1;
		end else if (fold_a < -ANG_QTR_IN) begin
			turn_a = fold_a + ANG_HALF_IN;
			rflip  = 1'b1;
		end

		rz    = ZW'(turn_a) <<< 8;
		rprod = 32'(radius_in) * 32'(GAIN_Q16);
		rx    = $signed({{(DW-32){1'b0}}, rprod});

		xneg = x_in[15];
		xs   = DW'(x_in);
		ys   = DW'(y_in);
		vx   = (xneg ? -xs : xs) <<< 16;
		vy   = (xneg ? -ys : ys) <<< 16;
		base = xneg ? (y_in[15] ? -DEG180 : DEG180) : '0;

		beat_d.mode   = command;
		beat_d.flip   = command ? 1'b0 : rflip;
		beat_d.origin = command & (x_in == 16'sd0) & (y_in == 16'sd0);
		beat_d.x      = command ? vx : rx;
		beat_d.y      = command ? vy : '0;
		beat_d.z      = command ? base : rz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		beat_s1 <= beat_d;
	end

endmodule

### rtl/pcc_stage.sv
`timescale 1ns / 1ps

module pcc_stage import pcc_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld_i,
	input  beat_t beat_i,
	output logic  vld_s1,
	output beat_t beat_s1
);

	beat_t beat_d;

	always_comb begin
		logic                 ccw;
		logic signed [DW-1:0] xs;
		logic signed [DW-1:0] ys;
		logic signed [ZW-1:0] at;

		ccw = beat_i.mode ? beat_i.y[DW-1] : !beat_i.z[ZW-1];
		xs  = beat_i.x >>> IDX;
		ys  = beat_i.y >>> IDX;
		at  = atan_lut(AIDX_W'(IDX));

		beat_d = beat_i;
		if (ccw) begin
			beat_d.x = beat_i.x - ys;
			beat_d.y = beat_i.y + xs;
			beat_d.z = beat_i.z - at;
		end else begin
			beat_d.x = beat_i.x + ys;
			beat_d.y = beat_i.y - xs;
			beat_d.z = beat_i.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		beat_s1 <= beat_d;
	end

endmodule

### rtl/pcc_post.sv
`timescale 1ns / 1ps

module pcc_post import pcc_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vld_i,
	input  beat_t                         beat_i,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] x_out,
	output logic signed [COORD_WIDTH-1:0] y_out,
	output logic        [15:0]            radius_out,
	output logic signed [15:0]            angle_out
);

	localparam int RW = DW + 1 - 16;
	localparam int SW = ((RW > COORD_WIDTH) ? RW : COORD_WIDTH) + 1;
	localparam logic signed [DW:0]   RND_XY = (DW+1)'(1) <<< 15;
	localparam logic signed [SW-1:0] C_HI   = SW'((longint'(1) <<< (COORD_WIDTH - 1)) - 1);
	localparam logic signed [SW-1:0] C_LO   = -C_HI - SW'(1);
	localparam logic [MAG_W+16:0]    RND_R  = (MAG_W+17)'(1) << 31;

	logic                       vld_s1;
	logic                       mode_s1;
	logic                       origin_s1;
	logic signed [DW:0]         sx_s1;
	logic signed [DW:0]         sy_s1;
	logic        [MAG_W+15:0]   prod_s1;
	logic signed [ZW-1:0]       za_s1;

	logic signed [DW:0]         sx_d;
	logic signed [DW:0]         sy_d;
	logic        [MAG_W+15:0]   prod_d;
	logic signed [ZW-1:0]       za_d;

	logic signed [COORD_WIDTH-1:0] x_d;
	logic signed [COORD_WIDTH-1:0] y_d;
	logic        [15:0]            r_d;
	logic signed [15:0]            a_d;

	always_comb begin
		logic signed [DW:0] xe;
		logic signed [DW:0] ye;

		xe     = (DW+1)'(beat_i.x);
		ye     = (DW+1)'(beat_i.y);
		sx_d   = beat_i.flip ? (RND_XY - xe) : (xe + RND_XY);
		sy_d   = beat_i.flip ? (RND_XY - ye) : (ye + RND_XY);
		prod_d = (MAG_W+16)'(beat_i.x[MAG_W-1:0]) * (MAG_W+16)'(GAIN_Q16);
		za_d   = beat_i.z + ZW'(128);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1   <= beat_i.mode;
		origin_s1 <= beat_i.origin;
		sx_s1     <= sx_d;
		sy_s1     <= sy_d;
		prod_s1   <= prod_d;
		za_s1     <= za_d;
	end

	always_comb begin
		logic signed [SW-1:0]    xv;
		logic signed [SW-1:0]    yv;
		logic signed [SW-1:0]    xc;
		logic signed [SW-1:0]    yc;
		logic        [MAG_W+16:0] rsum;
		logic        [17:0]      rq;
		logic signed [ZW-1:0]    av;
		logic signed [ZW-1:0]    ac;

		xv = SW'(sx_s1 >>> 16);
		yv = SW'(sy_s1 >>> 16);
		xc = (xv > C_HI) ? C_HI : ((xv < C_LO) ? C_LO : xv);
		yc = (yv > C_HI) ? C_HI : ((yv < C_LO) ? C_LO : yv);

		rsum = (MAG_W+17)'(prod_s1) + RND_R;
		rq   = 18'(rsum >> 32);

		av = za_s1 >>> 8;
		ac = (av > ANG_CLAMP) ? ANG_CLAMP : ((av < -ANG_CLAMP) ? -ANG_CLAMP : av);

		if (mode_s1) begin
			x_d = '0;
			y_d = '0;
			r_d = (rq[17:16] != 2'b00) ? 16'hFFFF : rq[15:0];
			a_d = origin_s1 ? 16'sd0 : ac[15:0];
		end else begin
			x_d = xc[COORD_WIDTH-1:0];
			y_d = yc[COORD_WIDTH-1:0];
			r_d = '0;
			a_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_out      <= x_d;
		y_out      <= y_d;
		radius_out <= r_d;
		angle_out  <= a_d;
	end

endmodule

### rtl/polar_cartesian_converter_unit.sv
`timescale 1ns / 1ps

// Channel  | Handshake            | Beat
// ---------+----------------------+----------------------------------------------
// command  | start & !busy        | command, x_in, y_in, radius_in, angle_in
// result   | done (one cycle)     | x_out, y_out, radius_out, angle_out
//
// A beat enters every cycle; busy is always low.
// The pipeline has one setup stage, one stage per CORDIC micro-rotation,
// one gain/rounding stage and one saturation/output stage.
// Reset clears the valid chain only; beats in flight are dropped.
// The receiver cannot stall, so results leave on done without back-pressure.

module polar_cartesian_converter_unit import pcc_pkg::*; #(
	parameter int ITERATIONS  = 16,
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic signed [15:0]            x_in,
	input  logic signed [15:0]            y_in,
	input  logic        [15:0]            radius_in,
	input  logic signed [15:0]            angle_in,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] x_out,
	output logic signed [COORD_WIDTH-1:0] y_out,
	output logic        [15:0]            radius_out,
	output logic signed [15:0]            angle_out
);

	localparam int LAT = ITERATIONS + 3;

	logic  vld_c  [0:ITERATIONS];
	beat_t beat_c [0:ITERATIONS];

	assign busy = 1'b0;

	pcc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (command),
		.x_in      (x_in),
		.y_in      (y_in),
		.radius_in (radius_in),
		.angle_in  (angle_in),
		.vld_s1    (vld_c[0]),
		.beat_s1   (beat_c[0])
	);

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
		pcc_stage #(
			.IDX (i)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_i   (vld_c[i]),
			.beat_i  (beat_c[i]),
			.vld_s1  (vld_c[i+1]),
			.beat_s1 (beat_c[i+1])
		);
	end

	pcc_post #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_i      (vld_c[ITERATIONS]),
		.beat_i     (beat_c[ITERATIONS]),
		.done       (done),
		.x_out      (x_out),
		.y_out      (y_out),
		.radius_out (radius_out),
		.angle_out  (angle_out)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result beat missing at pipeline latency");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle_out <= 16'sd23040 && angle_out >= -16'sd23040))
		else $error("angle_out outside half-turn range");

	a_mode_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (radius_out != 16'd0 || angle_out != 16'sd0)) |->
		(x_out == '0 && y_out == '0))
		else $error("polar and cartesian results both nonzero");

endmodule

### test/polar_cartesian_converter_unit_tb.sv
`timescale 1ns / 1ps

module polar_cartesian_converter_unit_tb;

	localparam int ITERATIONS     = 16;
	localparam int COORD_WIDTH    = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic CMD_TO_CART  = 1'b0;
	localparam logic CMD_TO_POLAR = 1'b1;

	localparam longint CORDIC_GAIN = 39797;
	localparam longint HALF_TURN   = 23040;
	localparam longint FULL_TURN   = 46080;
	localparam longint Z_DEG90     = 90 * 32768;
	localparam longint Z_DEG180    = 180 * 32768;
	localparam longint COORD_MAX   = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN   = -COORD_MAX - 1;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic        [15:0]            r;
		logic signed [15:0]            a;
	} conv_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic command;
	logic signed [15:0] x_in;
	logic signed [15:0] y_in;
	logic        [15:0] radius_in;
	logic signed [15:0] angle_in;
	logic done;
	logic signed [COORD_WIDTH-1:0] x_out;
	logic signed [COORD_WIDTH-1:0] y_out;
	logic        [15:0]            radius_out;
	logic signed [15:0]            angle_out;

	conv_result_t expected_results[$];
	int  error_count = 0;
	int  idle_cycles = 0;
	bit  idle_enable = 1'b1;

	// micro-rotation angles atan(2^-i) in 1/32768 degree
	longint atan_step [0:23] = '{
		1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
		7334, 3667, 1833, 917, 458, 229, 115, 57,
		29, 14, 7, 4, 2, 1, 0, 0
	};

	polar_cartesian_converter_unit #(
		.ITERATIONS (ITERATIONS),
		.COORD_WIDTH(COORD_WIDTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.x_in      (x_in),
		.y_in      (y_in),
		.radius_in (radius_in),
		.angle_in  (angle_in),
		.done      (done),
		.x_out     (x_out),
		.y_out     (y_out),
		.radius_out(radius_out),
		.angle_out (angle_out)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic conv_result_t predict_conversion(
		logic cmd, logic signed [15:0] xv, logic signed [15:0] yv,
		logic [15:0] rv, logic signed [15:0] av
	);
		conv_result_t res;
		longint px, py, pz, nx, ang, base;
		bit flip;
		int n_iter;
		res = '0;
		n_iter = (ITERATIONS > 24) ? 24 : ITERATIONS;
		if (cmd == CMD_TO_CART) begin
			ang = longint'(av);
			if (ang > HALF_TURN) ang -= FULL_TURN;
			if (ang < -HALF_TURN) ang += FULL_TURN;
			pz = ang * 256;
			flip = 1'b0;
			if (pz > Z_DEG90) begin
				pz -= Z_DEG180;
				flip = 1'b1;
			end else if (pz < -Z_DEG90) begin
				pz += Z_DEG180;
				flip = 1'b1;
			end
			px = longint'(rv);
			px = px * CORDIC_GAIN;
			py = 0;
			for (int i = 0; i < n_iter; i++) begin
				if (pz >= 0) begin
					nx = px - (py >>> i);
					py = py + (px >>> i);
					pz -= atan_step[i];
				end else begin
					nx = px + (py >>> i);
					py = py - (px >>> i);
					pz += atan_step[i];
				end
				px = nx;
			end
			if (flip) begin
				px = -px;
				py = -py;
			end
			res.x = COORD_WIDTH'(clamp((px + 32768) >>> 16, COORD_MIN, COORD_MAX));
			res.y = COORD_WIDTH'(clamp((py + 32768) >>> 16, COORD_MIN, COORD_MAX));
		end else if (xv != 0 || yv != 0) begin
			px = longint'(xv);
			py = longint'(yv);
			px = px * 65536;
			py = py * 65536;
			pz = 0;
			base = 0;
			if (xv < 0) begin
				px = -px;
				py = -py;
				base = (yv >= 0) ? Z_DEG180 : -Z_DEG180;
			end
			for (int i = 0; i < n_iter; i++) begin
				if (py >= 0) begin
					nx = px + (py >>> i);
					py = py - (px >>> i);
					pz += atan_step[i];
				end else begin
					nx = px - (py >>> i);
					py = py + (px >>> i);
					pz -= atan_step[i];
				end
				px = nx;
			end
			res.r = 16'(clamp((px * CORDIC_GAIN + 64'sd2147483648) >>> 32, 0, 65535));
			res.a = 16'(clamp((base + pz + 128) >>> 8, -HALF_TURN, HALF_TURN));
		end
		return res;
	endfunction

	task automatic send_beat(
		input logic cmd, input logic signed [15:0] xv, input logic signed [15:0] yv,
		input logic [15:0] rv, input logic signed [15:0] av
	);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start     <= 1'b1;
		command   <= cmd;
		x_in      <= xv;
		y_in      <= yv;
		radius_in <= rv;
		angle_in  <= av;
		do @(posedge clk); while (busy);
		expected_results.push_back(predict_conversion(cmd, xv, yv, rv, av));
	endtask

	// result check
	always @(posedge clk) begin
		conv_result_t exp_res;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with no beat pending", $time);
				error_count++;
			end else begin
				exp_res = expected_results.pop_front();
				if (x_out !== exp_res.x) begin
					$display("%0t: x_out expected %0d, actual %0d", $time, exp_res.x, x_out);
					error_count++;
				end
				if (y_out !== exp_res.y) begin
					$display("%0t: y_out expected %0d, actual %0d", $time, exp_res.y, y_out);
					error_count++;
				end
				if (radius_out !== exp_res.r) begin
					$display("%0t: radius_out expected %0d, actual %0d",
						$time, exp_res.r, radius_out);
					error_count++;
				end
				if (angle_out !== exp_res.a) begin
					$display("%0t: angle_out expected %0d, actual %0d",
						$time, exp_res.a, angle_out);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic test_polar_edges();
		logic signed [15:0] angles [12] = '{
			16'sd0, 16'sd11520, -16'sd11520, 16'sd11521, -16'sd11521, 16'sd23040,
			-16'sd23040, 16'sd23041, -16'sd23041, 16'sd32767, -16'sd32768, 16'sd5760
		};
		send_beat(CMD_TO_CART, 16'($urandom), 16'($urandom), 16'd0, 16'sd5760);
		foreach (angles[i])
			send_beat(CMD_TO_CART, 16'($urandom), 16'($urandom), 16'd46341, angles[i]);
	endtask

	task automatic test_cartesian_edges();
		logic signed [15:0] xs [12] = '{
			16'sd0, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd1,
			-16'sd256, -16'sd256, 16'sd0, 16'sd0, 16'sd1, -16'sd32768
		};
		logic signed [15:0] ys [12] = '{
			16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd0,
			16'sd0, -16'sd1, -16'sd32768, 16'sd32767, 16'sd0, 16'sd0
		};
		foreach (xs[i])
			send_beat(CMD_TO_POLAR, xs[i], ys[i], 16'($urandom), 16'($urandom));
	endtask

	task automatic run_random_beats(input int count);
		logic cmd;
		logic signed [15:0] xv, yv, av;
		logic [15:0] rv;
		repeat (count) begin
			cmd = 1'($urandom_range(0, 1));
			xv  = 16'($urandom);
			yv  = 16'($urandom);
			av  = 16'($urandom);
			rv  = 16'($urandom_range(0, 46341));
			if ($urandom_range(0, 3) == 0) begin
				xv = 16'($signed($urandom_range(0, 127)) - 64);
				yv = 16'($signed($urandom_range(0, 127)) - 64);
				rv = 16'($urandom_range(0, 1023));
			end
			send_beat(cmd, xv, yv, rv, av);
		end
	endtask

	task automatic test_random_with_gaps();
		idle_enable = 1'b1;
		run_random_beats(1100);
	endtask

	task automatic test_random_streaming();
		idle_enable = 1'b0;
		run_random_beats(576);
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		command   = CMD_TO_CART;
		x_in      = '0;
		y_in      = '0;
		radius_in = '0;
		angle_in  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_polar_edges();
		test_cartesian_edges();
		test_random_with_gaps();
		test_random_streaming();

		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (ITERATIONS + 8) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/pcc_pkg.sv
rtl/pcc_prep.sv
rtl/pcc_stage.sv
rtl/pcc_post.sv
rtl/polar_cartesian_converter_unit.sv
test/polar_cartesian_converter_unit_tb.sv
